### rtl/smhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smhpq_pkg: shared types and codes
// Word layouts of both channels, the ordering tuple and the status, command
// and register codes of the stable min-heap priority queue.
// ----------------------------------------------------------------------------
package smhpq_pkg;

  localparam int KEY_W   = 32;
  localparam int STAMP_W = 32;
  localparam int PAY_W   = 64;
  localparam int OCC_W   = 10;
  localparam int LVL_W   = 4;

  localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;
  localparam logic [LVL_W-1:0]   LEVELS_RST = 4'd10;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // word index of the register (paddr bit 2)
  localparam logic REG_LEVELS = 1'b0;

  typedef struct packed {
    logic                    command;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic [STAMP_W-1:0]      out_stamp;
    logic [OCC_W-1:0]        occupancy;
  } out_word_t;

  // ordering part of a heap entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [STAMP_W-1:0]      stamp;
  } ord_t;

endpackage
`default_nettype wire

### rtl/smhpq_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smhpq_cfg: configuration register
// APB-style access to levels_in_use; saturates the depth and derives the
// heap capacity.
// ----------------------------------------------------------------------------
module smhpq_cfg #(
  parameter int MAX_LEVELS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [MAX_LEVELS:0]   cap_o
);
  import smhpq_pkg::*;

  logic [LVL_W-1:0] levels_q, levels_d;
  logic [LVL_W:0]   lv_sat;
  logic             wr_hit;

  assign wr_hit = psel & penable & pwrite & (paddr[2] == REG_LEVELS);

  always_comb begin
    levels_d = levels_q;
    if (wr_hit) begin
      levels_d = pwdata[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= LEVELS_RST;
    end else begin
      levels_q <= levels_d;
    end
  end

  always_comb begin
    priority if (levels_q == '0) begin
      lv_sat = (LVL_W+1)'(1);
    end else if ({1'b0, levels_q} > (LVL_W+1)'(MAX_LEVELS)) begin
      lv_sat = (LVL_W+1)'(MAX_LEVELS);
    end else begin
      lv_sat = {1'b0, levels_q};
    end
  end

  assign cap_o  = ((MAX_LEVELS+1)'(1) << lv_sat) - (MAX_LEVELS+1)'(1);
  assign prdata = (paddr[2] == REG_LEVELS) ? 32'(levels_q) : '0;
  assign pready = 1'b1;

endmodule
`default_nettype wire

### rtl/smhpq_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smhpq_cmp: entry order compare
// True when entry a is served before entry b: smaller signed key, or equal
// keys and earlier stamp.
// ----------------------------------------------------------------------------
module smhpq_cmp (
  input  smhpq_pkg::ord_t a_i,
  input  smhpq_pkg::ord_t b_i,
  output logic            a_first_o
);
  import smhpq_pkg::*;

  always_comb begin
    if (a_i.key != b_i.key) begin
      a_first_o = $signed(a_i.key) < $signed(b_i.key);
    end else begin
      a_first_o = a_i.stamp < b_i.stamp;
    end
  end

endmodule
`default_nettype wire

### rtl/stable_min_heap_priority_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_min_heap_priority_queue_core: stable binary min-heap queue
// Heap in one RAM, sifted by a small sequencer around a shared order compare.
//
//   channel  dir  handshake             word
//   in       in   in_valid_i/in_stall_o   command, key, payload
//   out      out  out_valid_o/out_stall_i status, out_key, out_payload, ...
//   cfg      in   psel/penable/pwrite     levels_in_use at byte 0
//
// Enqueue sifts the new entry up level by level. Dequeue moves the last
// entry to the root and sifts it down level by level. The single
// RAM read port (registered data) sets the pace: one entry read per cycle.
// One word at a time; in_stall_o is high until the result is handed over.
// Reset clears state, count, stamp and out valid only; no clearing pass.
// A stalled out word holds and delays the next result, not the next accept.
// ----------------------------------------------------------------------------
module stable_min_heap_priority_queue_core #(
  parameter int MAX_LEVELS   = 10,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  smhpq_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output smhpq_pkg::out_word_t out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import smhpq_pkg::*;

  localparam int AW    = MAX_LEVELS;
  localparam int DEPTH = (1 << MAX_LEVELS) - 1;
  localparam int PB    = PAYLOAD_BITS;
  localparam int DW    = KEY_W + STAMP_W + PB;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SU_RD   = 4'd1;
  localparam logic [3:0] S_SU_CMP  = 4'd2;
  localparam logic [3:0] S_DQ_LAST = 4'd3;
  localparam logic [3:0] S_DQ_MOVE = 4'd4;
  localparam logic [3:0] S_SD_L    = 4'd5;
  localparam logic [3:0] S_SD_R    = 4'd6;
  localparam logic [3:0] S_SD_W    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      hole_q, hole_d;
  logic [AW-1:0]      child_q, child_d;
  logic [AW-1:0]      count_q, count_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic [DW-1:0]      mov_q, mov_d;
  logic [DW-1:0]      best_q, best_d;
  logic               best_left_q, best_left_d;
  out_word_t          res_q, res_d;
  out_word_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [DW-1:0]      mem [DEPTH];
  logic [DW-1:0]      rd_data_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [DW-1:0]      wr_data;

  logic [MAX_LEVELS:0] cap;
  logic               full, in_acc, a_first;
  ord_t               cmp_a, cmp_b;
  logic [AW:0]        left_w, right_w;
  logic [AW-1:0]      parent_w;

  smhpq_cfg #(.MAX_LEVELS(MAX_LEVELS)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  smhpq_cmp u_cmp (
    .a_i       (cmp_a),
    .b_i       (cmp_b),
    .a_first_o (a_first)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign full        = ({1'b0, count_q} >= cap);
  assign left_w      = {hole_q, 1'b1};
  assign right_w     = {1'b0, child_q} + (AW+1)'(1);
  assign parent_w    = (hole_q - AW'(1)) >> 1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d     = state_q;
    hole_d      = hole_q;
    child_d     = child_q;
    count_d     = count_q;
    stamp_d     = stamp_q;
    mov_d       = mov_q;
    best_d      = best_q;
    best_left_d = best_left_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = hole_q;
    wr_data     = mov_q;
    cmp_a       = ord_t'(mov_q[DW-1:PB]);
    cmp_b       = ord_t'(rd_data_q[DW-1:PB]);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          if (in_word_i.command == CMD_ENQ) begin
            if (full) begin
              res_d.status = ST_FULL;
              state_d      = S_DONE;
            end else begin
              hole_d  = count_q;
              count_d = count_q + AW'(1);
              mov_d   = {in_word_i.key, stamp_q, in_word_i.payload[PB-1:0]};
              if (stamp_q != STAMP_MAX) begin
                stamp_d = stamp_q + STAMP_W'(1);
              end
              state_d = S_SU_RD;
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              count_d = count_q - AW'(1);
              state_d = S_DQ_LAST;
            end
          end
        end
      end
      S_SU_RD: begin
        if (hole_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent_w;
          state_d = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        wr_en = 1'b1;
        if (a_first) begin
          wr_data = rd_data_q;
          hole_d  = parent_w;
          state_d = S_SU_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DQ_LAST: begin
        res_d.out_key     = rd_data_q[DW-1 -: KEY_W];
        res_d.out_stamp   = rd_data_q[PB+STAMP_W-1 -: STAMP_W];
        res_d.out_payload = PAY_W'(rd_data_q[PB-1:0]);
        rd_en             = 1'b1;
        rd_addr           = count_q;
        state_d           = S_DQ_MOVE;
      end
      S_DQ_MOVE: begin
        mov_d   = rd_data_q;
        hole_d  = '0;
        state_d = S_SD_L;
      end
      S_SD_L: begin
        if (left_w >= {1'b0, count_q}) begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = left_w[AW-1:0];
          child_d = left_w[AW-1:0];
          state_d = S_SD_R;
        end
      end
      S_SD_R: begin
        cmp_a       = ord_t'(rd_data_q[DW-1:PB]);
        cmp_b       = ord_t'(mov_q[DW-1:PB]);
        best_left_d = a_first;
        best_d      = a_first ? rd_data_q : mov_q;
        if (right_w < {1'b0, count_q}) begin
          rd_en   = 1'b1;
          rd_addr = right_w[AW-1:0];
          state_d = S_SD_W;
        end else if (a_first) begin
          wr_en   = 1'b1;
          wr_data = rd_data_q;
          hole_d  = child_q;
          state_d = S_SD_L;
        end else begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end
      end
      S_SD_W: begin
        cmp_a = ord_t'(rd_data_q[DW-1:PB]);
        cmp_b = ord_t'(best_q[DW-1:PB]);
        wr_en = 1'b1;
        priority if (a_first) begin
          wr_data = rd_data_q;
          hole_d  = right_w[AW-1:0];
          state_d = S_SD_L;
        end else if (best_left_q) begin
          wr_data = best_q;
          hole_d  = child_q;
          state_d = S_SD_L;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d           = res_q;
          out_d.occupancy = OCC_W'(count_q);
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q      <= hole_d;
    child_q     <= child_d;
    mov_q       <= mov_d;
    best_q      <= best_d;
    best_left_q <= best_left_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.command == CMD_ENQ) && full
    |=> (count_q == $past(count_q)) && (stamp_q == $past(stamp_q)))
    else $error("refused enqueue changed state");

  a_enq_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.command == CMD_ENQ) && !full
    |=> count_q == $past(count_q) + AW'(1))
    else $error("enqueue did not add an entry");

  a_deq_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.command == CMD_DEQ) && (count_q != '0)
    |=> count_q == $past(count_q) - AW'(1))
    else $error("dequeue did not remove an entry");

  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q != S_IDLE) && (state_q != S_DONE))
    else $error("heap written outside a sift");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !(out_valid_q && out_stall_i)
    |=> out_valid_o && (state_q == S_IDLE))
    else $error("result word not loaded");

endmodule
`default_nettype wire

### verif/tb_stable_min_heap_priority_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_stable_min_heap_priority_queue_core: self-checking bench for the heap queue
// A queue-fed driver sends enqueue and dequeue words in random bursts while
// the result side stalls on its own pattern. A heap model in the bench
// predicts every result word, and the monitor compares each field in order.
// Directed cases cover key extremes, ties, full and empty refusal, out of
// range depths, and a capacity lowered below occupancy. They are followed by
// a fill to all 255 entries at depth eight and random runs at several depths.
// ----------------------------------------------------------------------------
module tb_stable_min_heap_priority_queue_core;
  import smhpq_pkg::*;

  localparam int HEAP_SLOTS = 1023;
  localparam int FILL_SLOTS = 255;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [2:0] LEVELS_ADDR = {REG_LEVELS, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stable_min_heap_priority_queue_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // heap model state
  logic signed [KEY_W-1:0] heap_key   [HEAP_SLOTS];
  logic [PAY_W-1:0]        heap_pay   [HEAP_SLOTS];
  logic [STAMP_W-1:0]      heap_stamp [HEAP_SLOTS];
  int                      heap_count = 0;
  logic [STAMP_W-1:0]      stamp_next = '0;
  logic [LVL_W-1:0]        levels_cfg = LEVELS_RST;

  in_word_t  cmd_queue [$];
  out_word_t due_results [$];
  out_word_t want;
  int        fault_count = 0;
  logic      in_took = 1'b0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        stall_left = 0;
  int        stall_mode = 0;
  int        idle_cycles = 0;
  logic      drv_valid;
  in_word_t  drv_word;

  function automatic bit served_first(int a, int b);
    if (heap_key[a] != heap_key[b]) return heap_key[a] < heap_key[b];
    return heap_stamp[a] < heap_stamp[b];
  endfunction

  function automatic void swap_slots(int a, int b);
    logic signed [KEY_W-1:0] k;
    logic [PAY_W-1:0]        p;
    logic [STAMP_W-1:0]      s;
    k = heap_key[a];   heap_key[a] = heap_key[b];     heap_key[b] = k;
    p = heap_pay[a];   heap_pay[a] = heap_pay[b];     heap_pay[b] = p;
    s = heap_stamp[a]; heap_stamp[a] = heap_stamp[b]; heap_stamp[b] = s;
  endfunction

  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t r;
    int lv, cap, cur, parent, left, right, best;
    r = '0;
    r.status = ST_DONE;
    lv = int'(levels_cfg);
    if (lv < 1) lv = 1;
    if (lv > 10) lv = 10;
    cap = (1 << lv) - 1;
    if (w.command == CMD_ENQ) begin
      if (heap_count >= cap) begin
        r.status = ST_FULL;
      end else begin
        cur = heap_count;
        heap_key[cur] = w.key;
        heap_pay[cur] = w.payload;
        heap_stamp[cur] = stamp_next;
        if (stamp_next != STAMP_MAX) stamp_next++;
        heap_count++;
        while (cur > 0) begin
          parent = (cur - 1) / 2;
          if (!served_first(cur, parent)) break;
          swap_slots(cur, parent);
          cur = parent;
        end
      end
    end else if (heap_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.out_key = heap_key[0];
      r.out_payload = heap_pay[0];
      r.out_stamp = heap_stamp[0];
      heap_count--;
      heap_key[0] = heap_key[heap_count];
      heap_pay[0] = heap_pay[heap_count];
      heap_stamp[0] = heap_stamp[heap_count];
      cur = 0;
      while (1'b1) begin
        left = 2 * cur + 1;
        right = left + 1;
        best = cur;
        if (left < heap_count && served_first(left, best)) best = left;
        if (right < heap_count && served_first(right, best)) best = right;
        if (best == cur) break;
        swap_slots(cur, best);
        cur = best;
      end
    end
    r.occupancy = OCC_W'(heap_count);
    return r;
  endfunction

  task automatic flag_field(string what, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, what, exp_v, act_v);
      fault_count++;
    end
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return KEY_W'(int'($urandom_range(0, 8)) - 4);
      4: return KEY_W'(int'($urandom_range(0, 100)) - 50);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void push_enq(logic signed [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    in_word_t w;
    w.command = CMD_ENQ;
    w.key = k;
    w.payload = p;
    cmd_queue.push_back(w);
  endfunction

  // key and payload are don't-care on a dequeue; randomize them anyway
  function automatic void push_deq();
    in_word_t w;
    w.command = CMD_DEQ;
    w.key = $urandom;
    w.payload = {$urandom, $urandom};
    cmd_queue.push_back(w);
  endfunction

  task automatic settle();
    do @(negedge clk_i); while (cmd_queue.size() != 0 || due_results.size() != 0);
  endtask

  task automatic set_levels(logic [LVL_W-1:0] lv);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LEVELS_ADDR;
    pwdata <= 32'(lv);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    levels_cfg = lv;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    flag_field("levels readback", 64'(lv), 64'(prdata[LVL_W-1:0]));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // sender: bursts with random gaps, word held until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_took) void'(cmd_queue.pop_front());
      drv_valid = in_valid && !in_took;
      drv_word = in_word;
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0) begin
          drv_valid = 1'b1;
          drv_word = cmd_queue[0];
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid <= drv_valid;
      in_word <= drv_word;
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= stall_left[3];
    endcase
  end

  // monitor: check result words, then predict for the accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t mismatch: expected no word, actual %h", $time, out_word);
          fault_count++;
        end else begin
          want = due_results.pop_front();
          flag_field("status", 64'(want.status), 64'(out_word.status));
          flag_field("out_key", 64'(want.out_key), 64'(out_word.out_key));
          flag_field("out_payload", want.out_payload, out_word.out_payload);
          flag_field("out_stamp", 64'(want.out_stamp), 64'(out_word.out_stamp));
          flag_field("occupancy", 64'(want.occupancy), 64'(out_word.occupancy));
        end
      end
      if (in_valid && !in_stall) due_results.push_back(heap_apply(in_word));
    end
    in_took <= in_valid && !in_stall;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [LVL_W-1:0] seg_levels [6];
    int made, run, pick, fill;
    seg_levels = '{4'd10, 4'd4, 4'd15, 4'd7, 4'd3, 4'd10};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // key extremes, ties, empty at both ends
    push_deq();
    push_enq(32'sh7fff_ffff, '1);
    push_enq(32'sh8000_0000, '0);
    push_enq(32'sd0, {$urandom, $urandom});
    push_enq(-32'sd1, 64'haaaa_5555_aaaa_5555);
    for (int i = 1; i <= 4; i++) push_enq(32'sd5, PAY_W'(i));
    push_enq(-32'sd1, 64'h5555_aaaa_5555_aaaa);
    repeat (10) push_deq();
    settle();

    // single-entry heap, then depth zero clamps to one
    set_levels(4'd1);
    push_enq(32'sd7, pick_payload());
    push_enq(32'sd3, pick_payload());
    push_deq();
    push_deq();
    settle();
    set_levels(4'd0);
    push_enq(-32'sd9, pick_payload());
    push_enq(-32'sd9, pick_payload());
    push_deq();
    settle();

    // capacity lowered below occupancy
    set_levels(4'd15);
    repeat (25) push_enq(pick_key(), pick_payload());
    settle();
    set_levels(4'd2);
    repeat (3) push_enq(pick_key(), pick_payload());
    repeat (26) push_deq();
    repeat (4) push_enq(pick_key(), pick_payload());
    repeat (3) push_deq();
    settle();

    // fill to the full depth, refuse, drain past empty
    set_levels(4'd8);
    fill = FILL_SLOTS - heap_count + 2;
    repeat (fill) push_enq(pick_key(), pick_payload());
    repeat (fill) push_deq();
    settle();

    for (int seg = 0; seg < 6; seg++) begin
      set_levels(seg_levels[seg]);
      made = 0;
      while (made < 45) begin
        run = $urandom_range(1, 20);
        pick = $urandom_range(0, 2);
        repeat (run) begin
          if (pick == 0 || (pick == 2 && $urandom_range(0, 99) < 55)) begin
            push_enq(pick_key(), pick_payload());
          end else begin
            push_deq();
          end
        end
        made += run;
      end
      settle();
    end

    repeat (60) @(posedge clk_i);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
